FILE: src/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg - shared constants for the primitive root search block
// Field widths, the first candidate and the candidate cap.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int ROOT_W   = 7;
  localparam int MOD_IN_W = 31;
  localparam logic [ROOT_W-1:0] CAND_CAP = 7'd65;
  localparam logic [ROOT_W-1:0] CAND_FIRST = 7'd2;

endpackage

FILE: src/primitive_root_search_top.sv
// ----------------------------------------------------------------------------
// primitive_root_search_top - primitive roots of a modulus
// Factors p-1 by trial division, then tests candidates 2..limit.
// ----------------------------------------------------------------------------
// One modulus is taken at a time; in_tready is high only between moduli.
// Work per modulus is set by the bit-serial divider and the bit-serial
// modular multiplier: the divider runs the trial division of p-1, with
// divisors up to sqrt(p), and the multiplier the powers for each prime
// factor of each candidate. Results leave one word per root, ascending,
// the last flagged by out_tlast; out_tuser=0 marks the single no-root word.
module primitive_root_search_top #(
  parameter int MOD_BITS    = 31,
  parameter int MAX_FACTORS = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,   // [30:0] modulus
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,  // [6:0] root
  output logic                      out_tuser,  // [0] found
  output logic                      out_tlast,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [prs_pkg::ROOT_W-1:0] cfg_data  // [6:0] candidate_limit
);
  import prs_pkg::*;

  localparam int KW   = $clog2(MOD_BITS);
  localparam int FI_W = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
  localparam int NF_W = $clog2(MAX_FACTORS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TD    = 4'd1;
  localparam logic [3:0] S_TDW   = 4'd2;
  localparam logic [3:0] S_TDEND = 4'd3;
  localparam logic [3:0] S_EX    = 4'd4;
  localparam logic [3:0] S_EXW   = 4'd5;
  localparam logic [3:0] S_CAND  = 4'd6;
  localparam logic [3:0] S_CANDW = 4'd7;
  localparam logic [3:0] S_PSET  = 4'd8;
  localparam logic [3:0] S_SQ    = 4'd9;
  localparam logic [3:0] S_SQW   = 4'd10;
  localparam logic [3:0] S_ML    = 4'd11;
  localparam logic [3:0] S_MLW   = 4'd12;
  localparam logic [3:0] S_PNEXT = 4'd13;
  localparam logic [3:0] S_PUSH  = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  logic [3:0]          state_r, state_nxt;
  logic [ROOT_W-1:0]   lim_r, lim_nxt;
  logic [MOD_BITS-1:0] p_r, p_nxt;
  logic [MOD_BITS-1:0] pm1_r, pm1_nxt;
  logic [MOD_BITS-1:0] x_r, x_nxt;
  logic [MOD_BITS-1:0] i_r, i_nxt;
  logic                dm_r, dm_nxt;      // dividing out the current trial factor
  logic [NF_W-1:0]     nf_r, nf_nxt;
  logic [NF_W-1:0]     j_r, j_nxt;
  logic [ROOT_W-1:0]   g_r, g_nxt;
  logic [MOD_BITS-1:0] base_r, base_nxt;
  logic [MOD_BITS-1:0] acc_r, acc_nxt;
  logic [MOD_BITS-1:0] e_r, e_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  logic                hv_r, hv_nxt;
  logic [ROOT_W-1:0]   hold_r, hold_nxt;
  logic                ov_r, ov_nxt;
  logic [ROOT_W-1:0]   oroot_r, oroot_nxt;
  logic                ofound_r, ofound_nxt;
  logic                olast_r, olast_nxt;

  logic [MOD_BITS-1:0] fac_r [MAX_FACTORS];
  logic                fac_we;
  logic [FI_W-1:0]     fac_wa;
  logic [MOD_BITS-1:0] fac_wd;
  logic [MOD_BITS-1:0] fac_rd;

  logic                div_start, div_done;
  logic [MOD_BITS-1:0] div_a, div_b, div_q, div_rem;
  logic                mul_start, mul_done;
  logic [MOD_BITS-1:0] mul_b, mul_p;
  logic [MOD_BITS-1:0] acc_nxt_mul;

  logic [31:0]         in_word;
  logic [ROOT_W-1:0]   lim_sat;
  logic                out_free;
  logic                nf_room;

  assign in_word  = {1'b0, in_tdata[MOD_IN_W-1:0]};
  assign lim_sat  = (lim_r > CAND_CAP) ? CAND_CAP : lim_r;
  assign out_free = !ov_r || out_tready;
  assign nf_room  = nf_r < NF_W'(MAX_FACTORS);
  assign fac_rd   = fac_r[j_r[FI_W-1:0]];

  prs_div #(.MOD_BITS(MOD_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  prs_mulmod #(.MOD_BITS(MOD_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (acc_r),
    .b     (mul_b),
    .p     (mul_p),
    .done  (mul_done),
    .prod  (acc_nxt_mul)
  );

  assign mul_p = p_r;

  always_comb begin
    state_nxt  = state_r;
    lim_nxt    = lim_r;
    p_nxt      = p_r;
    pm1_nxt    = pm1_r;
    x_nxt      = x_r;
    i_nxt      = i_r;
    dm_nxt     = dm_r;
    nf_nxt     = nf_r;
    j_nxt      = j_r;
    g_nxt      = g_r;
    base_nxt   = base_r;
    acc_nxt    = acc_r;
    e_nxt      = e_r;
    k_nxt      = k_r;
    hv_nxt     = hv_r;
    hold_nxt   = hold_r;
    ov_nxt     = ov_r && !out_tready;
    oroot_nxt  = oroot_r;
    ofound_nxt = ofound_r;
    olast_nxt  = olast_r;
    fac_we     = 1'b0;
    fac_wa     = nf_r[FI_W-1:0];
    fac_wd     = x_r;
    div_start  = 1'b0;
    div_a      = x_r;
    div_b      = i_r;
    mul_start  = 1'b0;
    mul_b      = acc_r;

    if (cfg_valid) lim_nxt = cfg_data;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          p_nxt   = in_word[MOD_BITS-1:0];
          pm1_nxt = in_word[MOD_BITS-1:0] - 1'b1;
          x_nxt   = in_word[MOD_BITS-1:0] - 1'b1;
          i_nxt   = MOD_BITS'(2);
          dm_nxt  = 1'b0;
          nf_nxt  = '0;
          hv_nxt  = 1'b0;
          state_nxt = (in_word[MOD_BITS-1:0] < MOD_BITS'(2)) ? S_FIN : S_TD;
        end
      end
      S_TD: begin
        div_start = 1'b1;
        state_nxt = S_TDW;
      end
      S_TDW: begin
        if (div_done) begin
          if (!dm_r) begin
            // i*i <= x exactly when i <= x / i
            if (i_r > div_q) begin
              state_nxt = S_TDEND;
            end else if (div_rem == '0) begin
              fac_we = nf_room;
              fac_wd = i_r;
              if (nf_room) nf_nxt = nf_r + 1'b1;
              x_nxt  = div_q;
              dm_nxt = 1'b1;
              state_nxt = S_TD;
            end else begin
              i_nxt = i_r + 1'b1;
              state_nxt = S_TD;
            end
          end else begin
            if (div_rem == '0) begin
              x_nxt = div_q;
            end else begin
              dm_nxt = 1'b0;
              i_nxt  = i_r + 1'b1;
            end
            state_nxt = S_TD;
          end
        end
      end
      S_TDEND: begin
        if (x_r != MOD_BITS'(1) && nf_room) begin
          fac_we = 1'b1;
          fac_wd = x_r;
          nf_nxt = nf_r + 1'b1;
        end
        j_nxt = '0;
        state_nxt = S_EX;
      end
      S_EX: begin
        if (j_r == nf_r) begin
          g_nxt = CAND_FIRST;
          state_nxt = S_CAND;
        end else begin
          div_start = 1'b1;
          div_a = pm1_r;
          div_b = fac_rd;
          state_nxt = S_EXW;
        end
      end
      S_EXW: begin
        if (div_done) begin
          // factor slot now holds the exponent (p-1)/q
          fac_we = 1'b1;
          fac_wa = j_r[FI_W-1:0];
          fac_wd = div_q;
          j_nxt  = j_r + 1'b1;
          state_nxt = S_EX;
        end
      end
      S_CAND: begin
        if (g_r > lim_sat) begin
          state_nxt = S_FIN;
        end else begin
          div_start = 1'b1;
          div_a = MOD_BITS'(g_r);
          div_b = p_r;
          state_nxt = S_CANDW;
        end
      end
      S_CANDW: begin
        if (div_done) begin
          if (div_rem == '0) begin
            g_nxt = g_r + 1'b1;
            state_nxt = S_CAND;
          end else begin
            base_nxt = div_rem;
            j_nxt = '0;
            state_nxt = S_PSET;
          end
        end
      end
      S_PSET: begin
        if (j_r == nf_r) begin
          if (!hv_r) begin
            hv_nxt   = 1'b1;
            hold_nxt = g_r;
            g_nxt    = g_r + 1'b1;
            state_nxt = S_CAND;
          end else begin
            state_nxt = S_PUSH;
          end
        end else begin
          e_nxt   = fac_rd;
          acc_nxt = MOD_BITS'(1);
          k_nxt   = KW'(MOD_BITS - 1);
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        mul_start = 1'b1;
        mul_b = acc_r;
        state_nxt = S_SQW;
      end
      S_SQW: begin
        if (mul_done) begin
          acc_nxt = acc_nxt_mul;
          state_nxt = e_r[k_r] ? S_ML : S_PNEXT;
        end
      end
      S_ML: begin
        mul_start = 1'b1;
        mul_b = base_r;
        state_nxt = S_MLW;
      end
      S_MLW: begin
        if (mul_done) begin
          acc_nxt = acc_nxt_mul;
          state_nxt = S_PNEXT;
        end
      end
      S_PNEXT: begin
        if (k_r == '0) begin
          if (acc_r == MOD_BITS'(1)) begin
            g_nxt = g_r + 1'b1;
            state_nxt = S_CAND;
          end else begin
            j_nxt = j_r + 1'b1;
            state_nxt = S_PSET;
          end
        end else begin
          k_nxt = k_r - 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          oroot_nxt  = hold_r;
          ofound_nxt = 1'b1;
          olast_nxt  = 1'b0;
          hold_nxt   = g_r;
          g_nxt      = g_r + 1'b1;
          state_nxt  = S_CAND;
        end
      end
      S_FIN: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          oroot_nxt  = hv_r ? hold_r : '0;
          ofound_nxt = hv_r;
          olast_nxt  = 1'b1;
          hv_nxt     = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lim_r   <= CAND_CAP;
      hv_r    <= 1'b0;
      ov_r    <= 1'b0;
      nf_r    <= '0;
    end else begin
      state_r <= state_nxt;
      lim_r   <= lim_nxt;
      hv_r    <= hv_nxt;
      ov_r    <= ov_nxt;
      nf_r    <= nf_nxt;
    end
    p_r      <= p_nxt;
    pm1_r    <= pm1_nxt;
    x_r      <= x_nxt;
    i_r      <= i_nxt;
    dm_r     <= dm_nxt;
    j_r      <= j_nxt;
    g_r      <= g_nxt;
    base_r   <= base_nxt;
    acc_r    <= acc_nxt;
    e_r      <= e_nxt;
    k_r      <= k_nxt;
    hold_r   <= hold_nxt;
    oroot_r  <= oroot_nxt;
    ofound_r <= ofound_nxt;
    olast_r  <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (fac_we) fac_r[fac_wa] <= fac_wd;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, oroot_r};
  assign out_tuser  = ofound_r;
  assign out_tlast  = olast_r;

  a_nf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nf_r <= NF_W'(MAX_FACTORS))
    else $error("factor count overflow");

  a_none_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata == 8'd0)
    else $error("no-root word malformed");

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata >= 8'd2 && out_tdata <= {1'b0, CAND_CAP})
    else $error("root out of candidate range");

  a_hold_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !hv_r)
    else $error("pending root left over between moduli");

endmodule

FILE: src/prs_div.sv
// ----------------------------------------------------------------------------
// prs_div - bit-serial restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module prs_div #(
  parameter int MOD_BITS = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [MOD_BITS-1:0] dividend,
  input  logic [MOD_BITS-1:0] divisor,
  output logic                done,
  output logic [MOD_BITS-1:0] quot,
  output logic [MOD_BITS-1:0] rem
);
  localparam int KW = $clog2(MOD_BITS);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [KW-1:0]       cnt_r, cnt_nxt;
  logic [MOD_BITS-1:0] q_r, q_nxt;
  logic [MOD_BITS-1:0] rem_r, rem_nxt;
  logic [MOD_BITS-1:0] d_r, d_nxt;
  logic [MOD_BITS:0]   trial;
  logic [MOD_BITS:0]   diff;

  assign trial = {rem_r, q_r[MOD_BITS-1]};
  assign diff  = trial - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = KW'(MOD_BITS - 1);
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = diff[MOD_BITS-1:0];
        q_nxt   = {q_r[MOD_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[MOD_BITS-1:0];
        q_nxt   = {q_r[MOD_BITS-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

FILE: src/prs_mulmod.sv
// ----------------------------------------------------------------------------
// prs_mulmod - bit-serial modular multiplier
// Shift-add over the multiplier bits, MSB first, reduced every cycle.
// Operands must already be below the modulus.
// ----------------------------------------------------------------------------
module prs_mulmod #(
  parameter int MOD_BITS = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [MOD_BITS-1:0] a,
  input  logic [MOD_BITS-1:0] b,
  input  logic [MOD_BITS-1:0] p,
  output logic                done,
  output logic [MOD_BITS-1:0] prod
);
  localparam int KW = $clog2(MOD_BITS);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [KW-1:0]       cnt_r, cnt_nxt;
  logic [MOD_BITS-1:0] a_r, a_nxt;
  logic [MOD_BITS-1:0] b_r, b_nxt;
  logic [MOD_BITS-1:0] p_r, p_nxt;
  logic [MOD_BITS-1:0] acc_r, acc_nxt;
  logic [MOD_BITS+1:0] t;
  logic [MOD_BITS+1:0] p1;
  logic [MOD_BITS+1:0] p2;
  logic [MOD_BITS+1:0] red;

  assign p1 = {2'b00, p_r};
  assign p2 = {1'b0, p_r, 1'b0};
  // 2*acc + bit*a stays below 3p
  assign t  = {1'b0, acc_r, 1'b0} + (b_r[MOD_BITS-1] ? {2'b00, a_r} : '0);

  always_comb begin
    if (t >= p2)      red = t - p2;
    else if (t >= p1) red = t - p1;
    else              red = t;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = KW'(MOD_BITS - 1);
      a_nxt    = a;
      b_nxt    = b;
      p_nxt    = p;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = red[MOD_BITS-1:0];
      b_nxt   = {b_r[MOD_BITS-2:0], 1'b0};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    p_r   <= p_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
